/* rtl/lpd_pkg.sv */
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and codes for the length-prefixed list deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Width of the decimal fields and entry counters.
  localparam int unsigned COUNT_BITS = 32;
  // Accumulator with headroom for one multiply-by-ten step.
  localparam int unsigned ACC_W      = COUNT_BITS + 4;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // Parser phases.
  localparam logic [2:0] PH_COUNT   = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_END     = 3'd3;
  localparam logic [2:0] PH_ERRWAIT = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_OK    = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_INVALID  = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // Characters.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // One result transaction.
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [31:0] number;
    logic        last;
    logic [1:0]  err;
  } res_t;

endpackage

/* rtl/lpd_core.sv */
// ----------------------------------------------------------------------------
// lpd_core
// Frame parser state and per-byte decode; state advances on step.
// ----------------------------------------------------------------------------
module lpd_core import lpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  output res_t       res
);

  logic [2:0] phase_r, phase_nxt;
  logic       seen_r, seen_nxt;
  cnt_t       acc_r, acc_nxt;
  cnt_t       total_r, total_nxt;
  cnt_t       cnt_r, cnt_nxt;
  cnt_t       left_r, left_nxt;

  logic             is_digit;
  logic [3:0]       digit;
  logic [ACC_W-1:0] acc_ext;
  logic [ACC_W-1:0] scaled;
  logic             ovf;
  cnt_t             cnt_inc;
  logic             all_done;
  logic             last_byte;

  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit     = 4'(data_byte - CH_ZERO);
  assign acc_ext   = ACC_W'(acc_r);
  // acc*10 + d as (acc<<3) + (acc<<1) + d
  assign scaled    = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(digit);
  assign ovf       = |scaled[ACC_W-1:COUNT_BITS];
  assign cnt_inc   = cnt_r + cnt_t'(1);
  assign all_done  = (cnt_inc >= total_r);
  assign last_byte = (left_r <= cnt_t'(1));

  always_comb begin
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    acc_nxt   = acc_r;
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    res       = '0;

    if (frame_end) begin
      phase_nxt = PH_COUNT;
      seen_nxt  = 1'b0;
      acc_nxt   = '0;
      total_nxt = '0;
      cnt_nxt   = '0;
      left_nxt  = '0;
      case (phase_r)
        PH_ERRWAIT: ;
        PH_END: begin
          res.valid  = 1'b1;
          res.kind   = KIND_OK;
          res.number = 32'(total_r);
        end
        default: begin
          // early end
          res.valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_INVALID;
        end
      endcase
    end else begin
      case (phase_r)
        PH_COUNT, PH_LENGTH: begin
          if (is_digit) begin
            if (ovf) begin
              phase_nxt = PH_ERRWAIT;
              res.valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.err   = ERR_OVERFLOW;
            end else begin
              acc_nxt  = scaled[COUNT_BITS-1:0];
              seen_nxt = 1'b1;
            end
          end else if (data_byte != CH_COLON || !seen_r) begin
            phase_nxt = PH_ERRWAIT;
            res.valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_INVALID;
          end else begin
            acc_nxt  = '0;
            seen_nxt = 1'b0;
            if (phase_r == PH_COUNT) begin
              total_nxt = acc_r;
              cnt_nxt   = '0;
              phase_nxt = (acc_r == '0) ? PH_END : PH_LENGTH;
            end else if (acc_r == '0) begin
              res.valid  = 1'b1;
              res.kind   = KIND_EMPTY;
              res.number = 32'(cnt_r);
              cnt_nxt    = cnt_inc;
              phase_nxt  = all_done ? PH_END : PH_LENGTH;
            end else begin
              left_nxt  = acc_r;
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res.valid   = 1'b1;
          res.kind    = KIND_BYTE;
          res.payload = data_byte;
          res.number  = 32'(cnt_r);
          res.last    = last_byte;
          left_nxt    = last_byte ? '0 : left_r - cnt_t'(1);
          if (last_byte) begin
            cnt_nxt   = cnt_inc;
            phase_nxt = all_done ? PH_END : PH_LENGTH;
          end
        end
        PH_END: begin
          // extra bytes before the terminator
          phase_nxt = PH_ERRWAIT;
          res.valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_INVALID;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      seen_r  <= 1'b0;
      acc_r   <= '0;
      total_r <= '0;
      cnt_r   <= '0;
      left_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      acc_r   <= acc_nxt;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

/* rtl/length_prefixed_list_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_list_deframer
// Decodes "count:len:bytes..." frames into per-byte result transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one frame byte per transaction on in_data_byte,
//   or a terminator transaction with in_frame_end high that closes the frame.
//   Output channel (out_*): at most one result per input transaction:
//   a payload byte with its entry number and last mark, an empty-entry
//   notice, a frame-ok with the entry count, or a frame error with a code.
//   Both channels use valid/stall; a transaction moves when valid is high
//   and stall is low.
//   Path: an input transaction is registered in the input register, decoded
//   from there, and its result is registered in the result register for out_*.
//   Throughput: one transaction per cycle while no result is held by out_stall;
//   the parser's state update is a single pass (multiply-by-ten, count compare)
//   between the input register and the result register.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the count-digits phase; no clearing pass is needed.
//   When the receiver stalls with a result pending, the input register holds
//   one more transaction and in_stall rises until the result is taken.
//   After an error, bytes are dropped silently until a terminator re-arms.
// ----------------------------------------------------------------------------
module length_prefixed_list_deframer import lpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload,
  output logic [31:0] out_entry_number,
  output logic        out_entry_last,
  output logic [1:0]  out_error_code
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_payload_r;
  logic [31:0] out_number_r;
  logic        out_last_r;
  logic [1:0]  out_err_r;

  logic go;   // decode the held byte this cycle
  res_t res;

  // The held byte advances whenever the result slot is free or draining.
  assign go       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_end_r  <= in_frame_end;
    end
  end

  lpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (go),
    .data_byte (s1_byte_r),
    .frame_end (s1_end_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.valid) begin
      out_kind_r    <= res.kind;
      out_payload_r <= res.payload;
      out_number_r  <= res.number;
      out_last_r    <= res.last;
      out_err_r     <= res.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_payload      = out_payload_r;
  assign out_entry_number = out_number_r;
  assign out_entry_last   = out_last_r;
  assign out_error_code   = out_err_r;

`ifndef SYNTHESIS
  // an error result always carries a code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_error_code != ERR_NONE)
    else $error("error result without code");

  // non-error results carry no code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ERROR |-> out_error_code == ERR_NONE)
    else $error("code on non-error result");

  // last mark only on payload bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_last |-> out_kind == KIND_BYTE)
    else $error("last mark on non-byte result");

  // input backpressure only while a result is held up downstream
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
`endif

endmodule

/* tb/tb_length_prefixed_list_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_list_deframer
// Self-checking bench for the length-prefixed list deframer. A queue-fed
// driver streams frame bytes and terminators with random gaps. A behavioral
// deframer predicts each result at input acceptance. A monitor with random
// stalls and long hold-offs checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb_length_prefixed_list_deframer import lpd_pkg::*; ();

  localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);
  localparam longint unsigned RADIX   = 10;
  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no transaction at all
  localparam int unsigned HOLD_CYCLES = 100;   // long receiver hold-off

  // One input transaction plus its pacing.
  typedef struct {
    logic [7:0]  data;
    logic        term;
    int unsigned gap;    // idle cycles before it is offered
    bit          drain;  // offer only once all results are in
  } frame_item_t;

  // One result transaction, fields as on the out_* ports.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload;
    logic [31:0] number;
    logic        last;
    logic [1:0]  err;
  } frame_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload;
  logic [31:0] out_entry_number;
  logic        out_entry_last;
  logic [1:0]  out_error_code;

  length_prefixed_list_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload      (out_payload),
    .out_entry_number (out_entry_number),
    .out_entry_last   (out_entry_last),
    .out_error_code   (out_error_code)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  frame_item_t pending_bytes[$];    // input transactions not yet offered
  frame_res_t  expected_results[$]; // predicted results, oldest first
  logic [7:0]  frame_buf[$];        // scratch for building one frame
  bit          tx_calm = 1'b0;      // sender: no gaps while set
  bit          rx_calm = 1'b0;      // receiver: no stalls while set
  bit          drain_next = 1'b0;
  int unsigned n_bad = 0;
  int unsigned n_results = 0;

  // --------------------------------------------------------------------------
  // Behavioral deframer. State mirrors the block: phase, digit flag, decimal
  // accumulator, header count, entry index and bytes left in the entry.
  // --------------------------------------------------------------------------
  logic [2:0]      prs_phase = PH_COUNT;
  bit              prs_digit = 1'b0;
  longint unsigned prs_acc   = 0;
  longint unsigned prs_total = 0;
  longint unsigned prs_index = 0;
  longint unsigned prs_left  = 0;

  function automatic void flag_fault(input logic [1:0] code, output frame_res_t r);
    r        = '0;
    r.kind   = KIND_ERROR;
    r.err    = code;
    prs_phase = PH_ERRWAIT;
  endfunction

  function automatic void close_entry();
    prs_index++;
    prs_phase = (prs_index >= prs_total) ? PH_END : PH_LENGTH;
  endfunction

  // Returns 1 when the transaction yields a result, placed in r.
  function automatic bit deframe_predict(input logic [7:0] b, input logic term,
                                         output frame_res_t r);
    logic [2:0]      was_phase;
    longint unsigned total, val, dig;
    r = '0;
    if (term) begin
      // Terminator always re-arms; what it reports depends on where we were.
      was_phase = prs_phase;
      total     = prs_total;
      prs_phase = PH_COUNT;
      prs_digit = 1'b0;
      prs_acc   = 0;
      prs_total = 0;
      prs_index = 0;
      prs_left  = 0;
      if (was_phase == PH_ERRWAIT) return 1'b0;
      if (was_phase == PH_END) begin
        r.kind   = KIND_OK;
        r.number = total[31:0];
      end else begin
        r.kind = KIND_ERROR;
        r.err  = ERR_INVALID;  // frame ended early
      end
      return 1'b1;
    end
    case (prs_phase)
      PH_COUNT, PH_LENGTH: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          dig = 64'(b - CH_ZERO);
          if (prs_acc > (CNT_MAX - dig) / RADIX) begin
            flag_fault(ERR_OVERFLOW, r);
            return 1'b1;
          end
          prs_acc   = prs_acc * RADIX + dig;
          prs_digit = 1'b1;
          return 1'b0;
        end
        if (b != CH_COLON || !prs_digit) begin
          flag_fault(ERR_INVALID, r);  // bad separator or no digits
          return 1'b1;
        end
        val       = prs_acc;
        prs_acc   = 0;
        prs_digit = 1'b0;
        if (prs_phase == PH_COUNT) begin
          prs_total = val;
          prs_index = 0;
          prs_phase = (val == 0) ? PH_END : PH_LENGTH;
          return 1'b0;
        end
        if (val == 0) begin
          r.kind   = KIND_EMPTY;
          r.number = prs_index[31:0];
          close_entry();
          return 1'b1;
        end
        prs_left  = val;
        prs_phase = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        r.kind    = KIND_BYTE;
        r.payload = b;
        r.number  = prs_index[31:0];
        r.last    = (prs_left <= 1);
        prs_left  = r.last ? 0 : prs_left - 1;
        if (r.last) close_entry();
        return 1'b1;
      end
      PH_END: begin
        flag_fault(ERR_INVALID, r);  // bytes after the last entry
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_item(input logic [7:0] b, input logic term);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    pending_bytes.push_back('{b, term, gap, drain_next});
    drain_next = 1'b0;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endfunction

  // Decimal field into the frame buffer, now and then with leading zeros.
  function automatic void put_dec(input longint unsigned v);
    string s;
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) frame_buf.push_back(CH_ZERO);
    for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: directed frames, then random frames with some damaged
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n_entries, len, frame_no, pos;
    bit          with_term;

    // directed
    add_item(8'($urandom), 1'b1);             // terminator on an empty frame
    add_text("0:");  add_item(8'($urandom), 1'b1);  // zero entries, ok
    add_text("2:0:1:");                       // empty entry, one byte entry
    add_item(8'hFF, 1'b0);
    add_item("z", 1'b0);                      // extra byte before terminator
    add_item(8'($urandom), 1'b1);             // silent re-arm
    add_text(":");                            // colon with no digits
    add_item(8'h00, 1'b0);                    // dropped while in error
    add_item(8'($urandom), 1'b1);
    add_item(8'h00, 1'b0);                    // not a digit, not a colon
    add_item(8'($urandom), 1'b1);
    add_text("4294967296");                   // one past the counter range
    add_item(8'($urandom), 1'b1);

    // random
    frame_no   = 0;
    drain_next = 1'b1;
    while (pending_bytes.size() < 440) begin
      frame_buf.delete();
      tx_calm   = ($urandom_range(0, 4) == 0);
      with_term = 1'b1;
      if (frame_no % 12 == 11) drain_next = 1'b1;
      n_entries = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 4);
      put_dec(64'(n_entries));
      frame_buf.push_back(CH_COLON);
      repeat (n_entries) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
        put_dec(64'(len));
        frame_buf.push_back(CH_COLON);
        repeat (len) frame_buf.push_back(8'($urandom));
      end
      // about one frame in three gets damaged
      case ($urandom_range(0, 20))
        0, 1: begin  // cut short
          pos = $urandom_range(0, frame_buf.size() - 1);
          while (frame_buf.size() > pos) void'(frame_buf.pop_back());
        end
        2: frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom);
        3: frame_buf.insert($urandom_range(0, frame_buf.size()), 8'($urandom));
        4: repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
        5: begin  // header near the top of or just past the counter range
          frame_buf.delete();
          put_dec(64'd4294967290 + $urandom_range(0, 9));
          frame_buf.push_back(CH_COLON);
          repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
        end
        6: with_term = 1'b0;  // runs into the next frame
        default: ;
      endcase
      foreach (frame_buf[i]) add_item(frame_buf[i], 1'b0);
      if (with_term) add_item(8'($urandom), 1'b1);
      frame_no++;
    end

    // wait for the last transaction out, then for the pipeline to settle
    wait (rst_n);
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_bad == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Reset once at start.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: predicts on each accepted transaction, then offers the next item
  // once its gap has run out. Drain items also wait for an empty scoreboard.
  // --------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin : drive
    bit          free;
    frame_item_t nxt;
    frame_res_t  res;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'h00;
      in_frame_end <= 1'b0;
      idle_cycles  = 0;
    end else begin
      free = !in_valid;
      if (in_valid && !in_stall) begin
        if (deframe_predict(in_data_byte, in_frame_end, res)) expected_results.push_back(res);
        free        = 1'b1;
        idle_cycles = 0;
      end
      if (free) begin
        if (pending_bytes.size() != 0 && idle_cycles >= pending_bytes[0].gap &&
            !(pending_bytes[0].drain && expected_results.size() != 0)) begin
          nxt = pending_bytes.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= nxt.data;
          in_frame_end <= nxt.term;
        end else begin
          in_valid <= 1'b0;
          idle_cycles++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest prediction.
  // Random stall per result; twice a long hold-off so the block backs up
  // and raises in_stall while the driver keeps offering.
  // --------------------------------------------------------------------------
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin : watch
    frame_res_t got, want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_kind, out_payload, out_entry_number, out_entry_last, out_error_code};
        n_results++;
        if (expected_results.size() == 0) begin
          if (n_bad < 10)
            $display("%0t: unexpected result kind=%0d payload=%02h number=%0d last=%0b err=%0d",
                     $realtime, got.kind, got.payload, got.number, got.last, got.err);
          n_bad++;
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.payload !== want.payload ||
              got.number !== want.number || got.last !== want.last || got.err !== want.err) begin
            if (n_bad < 10) begin
              $display("%0t: mismatch exp kind=%0d payload=%02h number=%0d last=%0b err=%0d",
                       $realtime, want.kind, want.payload, want.number, want.last, want.err);
              $display("%0t:          got kind=%0d payload=%02h number=%0d last=%0b err=%0d",
                       $realtime, got.kind, got.payload, got.number, got.last, got.err);
            end
            n_bad++;
          end
        end
        if (n_results == 40 || n_results == 160) hold_left = HOLD_CYCLES;
        if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 12);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      if (hold_left != 0) hold_left--;
      out_stall <= (rx_wait != 0) || (hold_left != 0);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any transaction on either side means a hang.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin : hang_check
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

endmodule

/* filelist.f */
rtl/lpd_pkg.sv
rtl/lpd_core.sv
rtl/length_prefixed_list_deframer.sv
tb/tb_length_prefixed_list_deframer.sv
